### src/fsst_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arctangent table for the fire sector target test.
`default_nettype none
package fsst_pkg;

    localparam int COORD_W           = 32;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TAB_LEN           = 24;
    localparam int AXIS_W            = 16;
    localparam int CRD_W             = 34;
    localparam int ANG_W             = 32;
    localparam int LOC_W             = 30;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 16;
    localparam int UNIT_SHIFT        = 12;

    localparam logic signed [ANG_W-1:0] ANG_QUARTER = 32'sd47185920;
    localparam logic signed [ANG_W-1:0] ANG_HALF    = 32'sd94371840;
    localparam logic signed [ANG_W-1:0] ANG_FULL    = 32'sd188743680;
    localparam logic signed [ANG_W-1:0] ANG_EPS     = 32'sd52;
    localparam logic signed [31:0]      GAIN_Q30    = 32'sd652032874;
    localparam logic signed [15:0]      COS_EPS_Q30 = 16'sd1074;
    localparam logic signed [21:0]      POLE_SCALE  = 22'sd1000000;
    localparam logic [29:0]             NEAR_LIMIT  = 30'd17592186;
    localparam int NEAR_MAG      = 8192;
    localparam int UNITS_FULL    = 46080;
    localparam int UNITS_HALF    = 23040;
    localparam int UNITS_QUARTER = 11520;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ARC_MODE     = 3'd0,
        REG_CENTRE_YAW   = 3'd1,
        REG_CENTRE_PITCH = 3'd2,
        REG_YAW_WIDTH    = 3'd3,
        REG_PITCH_WIDTH  = 3'd4,
        REG_CONE_WIDTH   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [3*AXIS_W-1:0]       axis_right;
        logic [3*AXIS_W-1:0]       axis_up;
        logic [3*AXIS_W-1:0]       axis_forward;
        logic signed [COORD_W-1:0] owner_x;
        logic signed [COORD_W-1:0] owner_y;
        logic signed [COORD_W-1:0] owner_z;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
    } in_item_t;

    typedef struct packed {
        logic allowed;
        logic too_close;
    } out_item_t;

    // State handed from one CORDIC cell to the next.
    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    flip;
    } crd_t;

    // atan(2^-i) in 1/524288 degree.
    function automatic logic signed [ANG_W-1:0] atan_at(input int idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            0:  v = 32'sd23592960;
            1:  v = 32'sd13927738;
            2:  v = 32'sd7359034;
            3:  v = 32'sd3735561;
            4:  v = 32'sd1875029;
            5:  v = 32'sd938429;
            6:  v = 32'sd469329;
            7:  v = 32'sd234679;
            8:  v = 32'sd117341;
            9:  v = 32'sd58671;
            10: v = 32'sd29335;
            11: v = 32'sd14668;
            12: v = 32'sd7334;
            13: v = 32'sd3667;
            14: v = 32'sd1833;
            15: v = 32'sd917;
            16: v = 32'sd458;
            17: v = 32'sd229;
            18: v = 32'sd115;
            19: v = 32'sd57;
            20: v = 32'sd29;
            21: v = 32'sd14;
            22: v = 32'sd7;
            23: v = 32'sd4;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### src/fsst_cordic_cell.sv
`timescale 1ns / 1ps
// One registered CORDIC iteration, vectoring or rotation.
`default_nettype none
module fsst_cordic_cell #(
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b1,
    parameter int SB_W   = 1
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire fsst_pkg::crd_t  in_st,
    input  wire logic [SB_W-1:0] in_sb,
    output logic                 out_valid,
    output fsst_pkg::crd_t       out_st,
    output logic [SB_W-1:0]      out_sb
);

    logic signed [fsst_pkg::CRD_W-1:0] x_sh;
    logic signed [fsst_pkg::CRD_W-1:0] y_sh;
    logic signed [fsst_pkg::ANG_W-1:0] at;
    logic                              turn_pos;
    fsst_pkg::crd_t                    st_next;
    fsst_pkg::crd_t                    st_reg;
    logic                              valid_reg;
    logic [SB_W-1:0]                   sb_reg;

    always_comb
    begin
        x_sh     = in_st.x >>> STAGE;
        y_sh     = in_st.y >>> STAGE;
        at       = fsst_pkg::atan_at(STAGE);
        // vectoring drives y toward zero, rotation drives z toward zero
        turn_pos = VECTOR ? (in_st.y <= 0) : (in_st.z >= 0);
        st_next  = in_st;
        if (turn_pos)
        begin
            st_next.x = in_st.x - y_sh;
            st_next.y = in_st.y + x_sh;
            st_next.z = in_st.z - at;
        end
        else
        begin
            st_next.x = in_st.x + y_sh;
            st_next.y = in_st.y - x_sh;
            st_next.z = in_st.z + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
            sb_reg <= in_sb;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;
    assign out_sb    = sb_reg;

endmodule
`default_nettype wire

### src/fsst_cordic_chain.sv
`timescale 1ns / 1ps
// Row of CORDIC cells with quadrant pre-step and gain or sign post-step.
`default_nettype none
module fsst_cordic_chain #(
    parameter int STAGES = fsst_pkg::CORDIC_STAGES_DEF,
    parameter bit VECTOR = 1'b1,
    parameter int SB_W   = 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic signed [fsst_pkg::CRD_W-1:0] in_x,
    input  wire logic signed [fsst_pkg::CRD_W-1:0] in_y,
    input  wire logic signed [fsst_pkg::ANG_W-1:0] in_z,
    input  wire logic [SB_W-1:0]                   in_sb,
    output logic                                   out_valid,
    output logic signed [fsst_pkg::CRD_W-1:0]      out_x,
    output logic signed [fsst_pkg::CRD_W-1:0]      out_y,
    output logic signed [fsst_pkg::ANG_W-1:0]      out_z,
    output logic [SB_W-1:0]                        out_sb
);

    fsst_pkg::crd_t pre;
    fsst_pkg::crd_t pre_reg;
    logic           pre_valid_reg;
    logic [SB_W-1:0] pre_sb_reg;

    fsst_pkg::crd_t  st  [STAGES+1];
    logic            vld [STAGES+1];
    logic [SB_W-1:0] sb  [STAGES+1];

    logic signed [fsst_pkg::CRD_W+31:0] gain_prod;
    logic signed [fsst_pkg::CRD_W-1:0]  x_post;
    logic signed [fsst_pkg::CRD_W-1:0]  y_post;

    logic signed [fsst_pkg::CRD_W-1:0]  x_reg;
    logic signed [fsst_pkg::CRD_W-1:0]  y_reg;
    logic signed [fsst_pkg::ANG_W-1:0]  z_reg;
    logic                               valid_reg;
    logic [SB_W-1:0]                    sb_reg;

    always_comb
    begin
        pre.x    = in_x;
        pre.y    = in_y;
        pre.z    = in_z;
        pre.flip = 1'b0;
        if (VECTOR)
        begin
            // left half plane: mirror through origin, start from +-180
            if (in_x < 0)
            begin
                pre.x = -in_x;
                pre.y = -in_y;
                pre.z = in_z + ((in_y >= 0) ? fsst_pkg::ANG_HALF : -fsst_pkg::ANG_HALF);
            end
        end
        else
        begin
            if (in_z > fsst_pkg::ANG_QUARTER)
            begin
                pre.z    = in_z - fsst_pkg::ANG_HALF;
                pre.flip = 1'b1;
            end
            else if (in_z < -fsst_pkg::ANG_QUARTER)
            begin
                pre.z    = in_z + fsst_pkg::ANG_HALF;
                pre.flip = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_valid_reg <= 1'b0;
        else if (en)
            pre_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg    <= pre;
            pre_sb_reg <= in_sb;
        end
    end

    assign st[0]  = pre_reg;
    assign vld[0] = pre_valid_reg;
    assign sb[0]  = pre_sb_reg;

    for (genvar g = 0; g < STAGES; g++)
    begin : g_cell
        fsst_cordic_cell #(
            .STAGE  (g),
            .VECTOR (VECTOR),
            .SB_W   (SB_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vld[g]),
            .in_st     (st[g]),
            .in_sb     (sb[g]),
            .out_valid (vld[g+1]),
            .out_st    (st[g+1]),
            .out_sb    (sb[g+1])
        );
    end

    always_comb
    begin
        gain_prod = st[STAGES].x * fsst_pkg::GAIN_Q30;
        if (VECTOR)
            x_post = gain_prod[fsst_pkg::CRD_W+29:30];
        else
            x_post = st[STAGES].flip ? -st[STAGES].x : st[STAGES].x;
        y_post = st[STAGES].flip ? -st[STAGES].y : st[STAGES].y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= vld[STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= x_post;
            y_reg  <= y_post;
            z_reg  <= st[STAGES].z;
            sb_reg <= sb[STAGES];
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_sb    = sb_reg;

endmodule
`default_nettype wire

### src/fire_sector_target_test_unit.sv
`timescale 1ns / 1ps
// Top level: checks whether a target lies in the configured firing volume.
// Throughput: one item per cycle while no result beat is stalled.
// A stalled result beat freezes the whole pipeline and stalls the item channel.
// Reset (rst_n, async, active low) clears all valid bits and loads config defaults.
`default_nettype none
module fire_sector_target_test_unit #(
    parameter int CORDIC_STAGES = fsst_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire fsst_pkg::in_item_t                  item_data,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output fsst_pkg::out_item_t                      result_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fsst_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [fsst_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CRD_W    = fsst_pkg::CRD_W;
    localparam int ANG_W    = fsst_pkg::ANG_W;
    localparam int LOC_W    = fsst_pkg::LOC_W;
    localparam int AXIS_W   = fsst_pkg::AXIS_W;
    localparam int DIF_W    = fsst_pkg::COORD_W + 1;
    localparam int DN_W     = 34;
    localparam int W2       = (DIF_W > DN_W) ? DIF_W : DN_W;
    localparam int PROD_W   = DN_W + AXIS_W;
    localparam int RAW_W    = PROD_W + 2;
    localparam int DOT_W    = LOC_W + CRD_W + 2;
    localparam int CMP_W    = 2 * CRD_W + 2;
    localparam int SB1_W    = 1 + 3 * LOC_W;
    localparam int SB2_W    = SB1_W + ANG_W + CRD_W;
    localparam int DOWN_LIM = 33;
    localparam int NORM_LEN = 29;

    // ---------------- configuration registers ----------------
    logic        arc_mode_reg;
    logic [15:0] centre_yaw_reg;
    logic [14:0] centre_pitch_reg;
    logic [15:0] yaw_width_reg;
    logic [14:0] pitch_width_reg;
    logic [15:0] cone_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arc_mode_reg     <= 1'b0;
            centre_yaw_reg   <= '0;
            centre_pitch_reg <= '0;
            yaw_width_reg    <= 16'(fsst_pkg::UNITS_FULL);
            pitch_width_reg  <= 15'(fsst_pkg::UNITS_HALF);
            cone_width_reg   <= 16'(fsst_pkg::UNITS_FULL);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (fsst_pkg::cfg_reg_t'(cfg_index))
                fsst_pkg::REG_ARC_MODE:     arc_mode_reg     <= cfg_data[0];
                fsst_pkg::REG_CENTRE_YAW:   centre_yaw_reg   <= cfg_data;
                fsst_pkg::REG_CENTRE_PITCH: centre_pitch_reg <= cfg_data[14:0];
                fsst_pkg::REG_YAW_WIDTH:    yaw_width_reg    <= cfg_data;
                fsst_pkg::REG_PITCH_WIDTH:  pitch_width_reg  <= cfg_data[14:0];
                fsst_pkg::REG_CONE_WIDTH:   cone_width_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Normalized config: yaw wrapped, pitch clamped, widths saturated, scaled
    // into internal angle units (4096 per config unit).
    logic signed [16:0]      cy;
    logic signed [14:0]      cp;
    logic [15:0]             yw;
    logic [14:0]             pw;
    logic [15:0]             cw;
    logic signed [ANG_W-1:0] cy_ang;
    logic signed [ANG_W-1:0] cp_ang;
    logic signed [ANG_W-1:0] cw_ang;
    logic signed [ANG_W-1:0] yaw_lim;
    logic signed [ANG_W-1:0] pitch_lim;
    logic                    yaw_full;
    logic                    cone_full;

    always_comb
    begin
        cy = 17'($signed(centre_yaw_reg));
        if (cy > 17'sd23040)
            cy = cy - 17'sd46080;
        else if (cy < -17'sd23040)
            cy = cy + 17'sd46080;
        cp = $signed(centre_pitch_reg);
        if (cp > 15'sd11520)
            cp = 15'sd11520;
        else if (cp < -15'sd11520)
            cp = -15'sd11520;
        yw = (yaw_width_reg > 16'(fsst_pkg::UNITS_FULL)) ?
             16'(fsst_pkg::UNITS_FULL) : yaw_width_reg;
        pw = (pitch_width_reg > 15'(fsst_pkg::UNITS_HALF)) ?
             15'(fsst_pkg::UNITS_HALF) : pitch_width_reg;
        cw = (cone_width_reg > 16'(fsst_pkg::UNITS_FULL)) ?
             16'(fsst_pkg::UNITS_FULL) : cone_width_reg;
        yaw_full  = (yaw_width_reg >= 16'(fsst_pkg::UNITS_FULL));
        cone_full = (cone_width_reg >= 16'(fsst_pkg::UNITS_FULL));
        cy_ang    = ANG_W'(cy) <<< fsst_pkg::UNIT_SHIFT;
        cp_ang    = ANG_W'(cp) <<< fsst_pkg::UNIT_SHIFT;
        // half widths: width * 4096 / 2
        cw_ang    = $signed(ANG_W'(cw) << (fsst_pkg::UNIT_SHIFT - 1));
        yaw_lim   = $signed(ANG_W'(yw) << (fsst_pkg::UNIT_SHIFT - 1)) + fsst_pkg::ANG_EPS;
        pitch_lim = $signed(ANG_W'(pw) << (fsst_pkg::UNIT_SHIFT - 1)) + fsst_pkg::ANG_EPS;
    end

    // ---------------- config-side rotation rows (free running) ----------------
    // The user must make config changes only while idle; the block does not enforce it.
    // Given that, these rows settle well before any item reaches the dot product stage.
    logic                    ry_valid, rp_valid, rw_valid;
    logic signed [CRD_W-1:0] cyc, cys, cpc, cps, ch;
    logic [0:0]              ry_sb, rp_sb, rw_sb;

    fsst_cordic_chain #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .SB_W(1)) u_rot_yaw (
        .clk (clk), .rst_n (rst_n), .en (1'b1), .in_valid (1'b1),
        .in_x (CRD_W'(fsst_pkg::GAIN_Q30)), .in_y ('0), .in_z (cy_ang),
        .in_sb (arc_mode_reg),
        .out_valid (ry_valid), .out_x (cyc), .out_y (cys), .out_z (), .out_sb (ry_sb)
    );

    fsst_cordic_chain #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .SB_W(1)) u_rot_pitch (
        .clk (clk), .rst_n (rst_n), .en (1'b1), .in_valid (1'b1),
        .in_x (CRD_W'(fsst_pkg::GAIN_Q30)), .in_y ('0), .in_z (cp_ang),
        .in_sb (cone_full),
        .out_valid (rp_valid), .out_x (cpc), .out_y (cps), .out_z (), .out_sb (rp_sb)
    );

    fsst_cordic_chain #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .SB_W(1)) u_rot_cone (
        .clk (clk), .rst_n (rst_n), .en (1'b1), .in_valid (1'b1),
        .in_x (CRD_W'(fsst_pkg::GAIN_Q30)), .in_y ('0), .in_z (cw_ang),
        .in_sb (yaw_full),
        .out_valid (rw_valid), .out_x (ch), .out_y (), .out_z (), .out_sb (rw_sb)
    );

    // center direction components: right = sin(yaw)cos(pitch), fwd = cos(yaw)cos(pitch)
    logic signed [2*CRD_W-1:0] cr_prod, cf_prod;
    logic signed [CRD_W-1:0]   cr_reg, cf_reg, cps_reg, ch_reg;
    logic                      arc_reg, cone_full_reg, yaw_full_reg, rot_live_reg;

    assign cr_prod = cys * cpc;
    assign cf_prod = cyc * cpc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rot_live_reg <= 1'b0;
        else
            rot_live_reg <= ry_valid && rp_valid && rw_valid;
    end

    always_ff @(posedge clk)
    begin
        cr_reg        <= cr_prod[CRD_W+29:30];
        cf_reg        <= cf_prod[CRD_W+29:30];
        cps_reg       <= cps;
        ch_reg        <= ch;
        arc_reg       <= ry_sb[0];
        cone_full_reg <= rp_sb[0];
        yaw_full_reg  <= rw_sb[0];
    end

    // ---------------- item pipeline ----------------
    // Whole pipeline advances unless the output register holds a stalled beat.
    logic adv;
    logic out_valid_reg;
    assign adv        = !(out_valid_reg && result_stall);
    assign item_stall = !adv;

    // S1: world difference
    logic [3*AXIS_W-1:0]       axis_in [3];
    logic signed [DIF_W-1:0]   d_next  [3];
    logic signed [DIF_W-1:0]   d_reg   [3];
    logic signed [AXIS_W-1:0]  ax1_reg [3][3];
    logic signed [AXIS_W-1:0]  ax2_reg [3][3];
    logic                      v1_reg;

    always_comb
    begin
        axis_in[0] = item_data.axis_right;
        axis_in[1] = item_data.axis_up;
        axis_in[2] = item_data.axis_forward;
        d_next[0]  = DIF_W'(item_data.target_x) - DIF_W'(item_data.owner_x);
        d_next[1]  = DIF_W'(item_data.target_y) - DIF_W'(item_data.owner_y);
        d_next[2]  = DIF_W'(item_data.target_z) - DIF_W'(item_data.owner_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d_reg[k] <= d_next[k];
                for (int j = 0; j < 3; j++)
                    ax1_reg[k][j] <= $signed(axis_in[k][AXIS_W*j +: AXIS_W]);
            end
        end
    end

    // S2: scale very long differences down toward zero
    logic [DIF_W-1:0]       d_mag [3];
    logic [DIF_W-1:0]       d_or;
    logic [6:0]             bl1;
    logic [6:0]             dn1;
    logic [W2-1:0]          d_sh  [3];
    logic signed [DN_W-1:0] dn_next [3];
    logic signed [DN_W-1:0] dn_reg  [3];
    logic                   wide2_reg;
    logic                   v2_reg;

    always_comb
    begin
        d_or = '0;
        for (int j = 0; j < 3; j++)
        begin
            d_mag[j] = d_reg[j][DIF_W-1] ? DIF_W'(-d_reg[j]) : DIF_W'(d_reg[j]);
            d_or     = d_or | d_mag[j];
        end
        bl1 = '0;
        for (int b = 0; b < DIF_W; b++)
            if (d_or[b])
                bl1 = 7'(b + 1);
        dn1 = (bl1 > 7'(DOWN_LIM)) ? (bl1 - 7'(DOWN_LIM)) : 7'd0;
        for (int j = 0; j < 3; j++)
        begin
            d_sh[j]    = W2'(d_mag[j]) >> dn1;
            d_sh[j]    = d_reg[j][DIF_W-1] ? -d_sh[j] : d_sh[j];
            dn_next[j] = $signed(d_sh[j][DN_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dn_reg    <= dn_next;
            ax2_reg   <= ax1_reg;
            wide2_reg <= (dn1 != 7'd0);
        end
    end

    // S3: nine axis products
    logic signed [PROD_W-1:0] p_reg [3][3];
    logic                     wide3_reg;
    logic                     v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
                for (int j = 0; j < 3; j++)
                    p_reg[k][j] <= dn_reg[j] * ax2_reg[k][j];
            wide3_reg <= wide2_reg;
        end
    end

    // S4: local components right, up, forward
    logic signed [RAW_W-1:0] raw4_reg [3];
    logic                    wide4_reg;
    logic                    v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
                raw4_reg[k] <= RAW_W'(p_reg[k][0]) + RAW_W'(p_reg[k][1]) +
                               RAW_W'(p_reg[k][2]);
            wide4_reg <= wide3_reg;
        end
    end

    // S5: too-close distance test and normalizing shift amounts
    logic [RAW_W-1:0] raw_mag [3];
    logic [RAW_W-1:0] raw_or;
    logic [27:0]      sq [3];
    logic [29:0]      sum_sq;
    logic             any_big;
    logic             all_zero;
    logic             close5;
    logic [5:0]       bl2;
    logic [5:0]       dn2;
    logic [4:0]       up2;
    logic signed [RAW_W-1:0] raw5_reg [3];
    logic             close5_reg;
    logic [5:0]       dn5_reg;
    logic [4:0]       up5_reg;
    logic             v5_reg;

    always_comb
    begin
        raw_or   = '0;
        any_big  = 1'b0;
        all_zero = 1'b1;
        sum_sq   = '0;
        for (int k = 0; k < 3; k++)
        begin
            raw_mag[k] = raw4_reg[k][RAW_W-1] ? RAW_W'(-raw4_reg[k]) : RAW_W'(raw4_reg[k]);
            raw_or     = raw_or | raw_mag[k];
            any_big    = any_big || (raw_mag[k] > RAW_W'(fsst_pkg::NEAR_MAG));
            all_zero   = all_zero && (raw4_reg[k] == '0);
            sq[k]      = raw_mag[k][13:0] * raw_mag[k][13:0];
            sum_sq     = sum_sq + 30'(sq[k]);
        end
        if (wide4_reg)
            close5 = all_zero;
        else
            close5 = !any_big && (sum_sq <= fsst_pkg::NEAR_LIMIT);
        bl2 = '0;
        for (int b = 0; b < RAW_W; b++)
            if (raw_or[b])
                bl2 = 6'(b + 1);
        dn2 = (bl2 > 6'(NORM_LEN)) ? (bl2 - 6'(NORM_LEN)) : 6'd0;
        up2 = (bl2 < 6'(NORM_LEN)) ? 5'(6'(NORM_LEN) - bl2) : 5'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (adv)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            raw5_reg   <= raw4_reg;
            close5_reg <= close5;
            dn5_reg    <= dn2;
            up5_reg    <= up2;
        end
    end

    // S6: normalize so the largest component sits in [2^28, 2^29)
    logic [RAW_W-1:0]        n_mag [3];
    logic [RAW_W-1:0]        n_sh  [3];
    logic signed [LOC_W-1:0] loc6_reg [3];
    logic                    close6_reg;
    logic                    v6_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            n_mag[k] = raw5_reg[k][RAW_W-1] ? RAW_W'(-raw5_reg[k]) : RAW_W'(raw5_reg[k]);
            n_sh[k]  = (n_mag[k] >> dn5_reg) << up5_reg;
            n_sh[k]  = raw5_reg[k][RAW_W-1] ? -n_sh[k] : n_sh[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (adv)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
                loc6_reg[k] <= $signed(n_sh[k][LOC_W-1:0]);
            close6_reg <= close5_reg;
        end
    end

    // Vectoring row 1: yaw = atan2(right, forward), h = horizontal length
    logic                    va_valid;
    logic signed [CRD_W-1:0] h_a;
    logic signed [ANG_W-1:0] yaw_a;
    logic [SB1_W-1:0]        sb_a;

    fsst_cordic_chain #(.STAGES(CORDIC_STAGES), .VECTOR(1'b1), .SB_W(SB1_W)) u_vec_yaw (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (v6_reg),
        .in_x (CRD_W'(loc6_reg[2])), .in_y (CRD_W'(loc6_reg[0])), .in_z ('0),
        .in_sb ({close6_reg, loc6_reg[0], loc6_reg[1], loc6_reg[2]}),
        .out_valid (va_valid), .out_x (h_a), .out_y (), .out_z (yaw_a), .out_sb (sb_a)
    );

    // Vectoring row 2: pitch = atan2(up, h), len = full length
    logic                    vb_valid;
    logic signed [CRD_W-1:0] len_b;
    logic signed [ANG_W-1:0] pitch_b;
    logic [SB2_W-1:0]        sb_b;

    fsst_cordic_chain #(.STAGES(CORDIC_STAGES), .VECTOR(1'b1), .SB_W(SB2_W)) u_vec_pitch (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (va_valid),
        .in_x (h_a), .in_y (CRD_W'($signed(sb_a[2*LOC_W-1:LOC_W]))), .in_z ('0),
        .in_sb ({sb_a, yaw_a, h_a}),
        .out_valid (vb_valid), .out_x (len_b), .out_y (), .out_z (pitch_b), .out_sb (sb_b)
    );

    // unpack row 2 sideband
    logic                    close_b;
    logic signed [LOC_W-1:0] l0_b, l1_b, l2_b;
    logic signed [ANG_W-1:0] yaw_b;
    logic signed [CRD_W-1:0] h_b;

    assign h_b     = $signed(sb_b[CRD_W-1:0]);
    assign yaw_b   = $signed(sb_b[CRD_W +: ANG_W]);
    assign l2_b    = $signed(sb_b[CRD_W+ANG_W +: LOC_W]);
    assign l1_b    = $signed(sb_b[CRD_W+ANG_W+LOC_W +: LOC_W]);
    assign l0_b    = $signed(sb_b[CRD_W+ANG_W+2*LOC_W +: LOC_W]);
    assign close_b = sb_b[SB2_W-1];

    // S7: dot product terms, cone threshold products, pole test product
    logic signed [LOC_W+CRD_W-1:0] q0_reg, q1_reg, q2_reg;
    logic signed [2*CRD_W-1:0]     chl_reg;
    logic signed [CRD_W+15:0]      epl_reg;
    logic signed [CRD_W+21:0]      hm_reg;
    logic signed [CRD_W-1:0]       len7_reg;
    logic signed [ANG_W-1:0]       yaw7_reg;
    logic signed [ANG_W-1:0]       pitch7_reg;
    logic                          close7_reg;
    logic                          v7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (adv)
            v7_reg <= vb_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q0_reg     <= l0_b * cr_reg;
            q1_reg     <= l1_b * cps_reg;
            q2_reg     <= l2_b * cf_reg;
            chl_reg    <= ch_reg * len_b;
            epl_reg    <= len_b * fsst_pkg::COS_EPS_Q30;
            hm_reg     <= h_b * fsst_pkg::POLE_SCALE;
            len7_reg   <= len_b;
            yaw7_reg   <= yaw_b;
            pitch7_reg <= pitch_b;
            close7_reg <= close_b;
        end
    end

    // S8: decisions into the output register
    logic signed [DOT_W-1:0] dot;
    logic signed [CMP_W-1:0] lhs;
    logic                    cone_ok;
    logic signed [ANG_W-1:0] yaw_sel;
    logic signed [ANG_W-1:0] dy;
    logic signed [ANG_W-1:0] dp;
    logic                    box_ok;
    fsst_pkg::out_item_t     res_next;
    fsst_pkg::out_item_t     res_reg;

    always_comb
    begin
        dot     = DOT_W'(q0_reg) + DOT_W'(q1_reg) + DOT_W'(q2_reg);
        lhs     = CMP_W'(dot) + CMP_W'(epl_reg);
        cone_ok = (lhs >= CMP_W'(chl_reg));

        // near the poles yaw is undefined: take the centre yaw
        yaw_sel = (hm_reg <= (CRD_W+22)'(len7_reg)) ? cy_ang : yaw7_reg;
        dy = yaw_sel - cy_ang;
        if (dy >= fsst_pkg::ANG_FULL)
            dy = dy - fsst_pkg::ANG_FULL;
        if (dy <= -fsst_pkg::ANG_FULL)
            dy = dy + fsst_pkg::ANG_FULL;
        if (dy > fsst_pkg::ANG_HALF)
            dy = dy - fsst_pkg::ANG_FULL;
        if (dy < -fsst_pkg::ANG_HALF)
            dy = dy + fsst_pkg::ANG_FULL;
        dy = (dy < 0) ? -dy : dy;
        dp = pitch7_reg - cp_ang;
        dp = (dp < 0) ? -dp : dp;
        box_ok = (yaw_full_reg || (dy <= yaw_lim)) && (dp <= pitch_lim);

        res_next.too_close = close7_reg;
        if (close7_reg)
            res_next.allowed = 1'b0;
        else if (arc_reg)
            res_next.allowed = cone_full_reg || cone_ok;
        else
            res_next.allowed = box_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v7_reg && rot_live_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = res_reg;

endmodule
`default_nettype wire

### src/fsst_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the fire sector target test unit, bound to the top.
`default_nettype none
module fsst_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            item_stall,
    input wire logic                            result_valid,
    input wire logic                            result_stall,
    input wire fsst_pkg::out_item_t             result_data
);

    // a refused target is never allowed
    a_close_not_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.too_close |-> !result_data.allowed)
        else $error("too_close beat also flagged allowed");

    // item side stalls exactly while a result beat is held
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall == (result_valid && result_stall))
        else $error("item stall does not follow held result");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result_data))
        else $error("result payload changed while stalled");

endmodule

bind fire_sector_target_test_unit fsst_checker u_fsst_checker (.*);
`default_nettype wire
